// ----- rtl/core/aes_round_three_lane_mac_macros.svh -----
// assertion macros for the three-lane round mac checker
`ifndef AES_ROUND_THREE_LANE_MAC_MACROS_SVH
`define AES_ROUND_THREE_LANE_MAC_MACROS_SVH
// implication checked every clock edge outside reset
`define ARM_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// next-cycle implication
`define ARM_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

// ----- rtl/core/armac_pkg.sv -----
// shared types, constants and aes round functions for the three-lane mac
`timescale 1ns / 1ps
`default_nettype none
package armac_pkg;
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_AAD = 2'd1;
	localparam logic [1:0] OP_TEXT = 2'd2;
	localparam logic [1:0] OP_FINISH = 2'd3;

	localparam logic [2:0] REG_RATE = 3'd0;
	localparam logic [2:0] REG_KEY0 = 3'd1;
	localparam logic [2:0] REG_KEY1 = 3'd2;
	localparam logic [2:0] REG_KEY2 = 3'd3;
	localparam logic [2:0] REG_KEY3 = 3'd4;
	localparam logic [2:0] REG_TAG = 3'd5;

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	localparam logic [3:0] PERM [3][16] = '{
		'{4'd0, 4'd7, 4'd14, 4'd11, 4'd4, 4'd13, 4'd10, 4'd1,
		  4'd8, 4'd15, 4'd6, 4'd3, 4'd12, 4'd5, 4'd2, 4'd9},
		'{4'd7, 4'd14, 4'd15, 4'd10, 4'd12, 4'd13, 4'd3, 4'd0,
		  4'd4, 4'd6, 4'd1, 4'd5, 4'd8, 4'd11, 4'd2, 4'd9},
		'{4'd0, 4'd11, 4'd7, 4'd14, 4'd6, 4'd4, 4'd1, 4'd15,
		  4'd9, 4'd3, 4'd8, 4'd5, 4'd13, 4'd2, 4'd10, 4'd12}};

	localparam int unsigned INIT_ROUNDS = 9;
	localparam logic [127:0] ONE_MSG = 128'd1;

	function automatic logic [7:0] xt(input logic [7:0] v);
		xt = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	// one aes round (sub, shift, mix) with k xored in; byte i sits at bits 8i
	function automatic logic [127:0] aes_round(input logic [127:0] a, input logic [127:0] k);
		logic [7:0] s [16];
		logic [7:0] a0, a1, a2, a3, t;
		logic [127:0] d;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				s[r + 4 * c] = SBOX[a[8 * (r + 4 * ((c + r) % 4)) +: 8]];
		for (int c = 0; c < 4; c++) begin
			a0 = s[4 * c];
			a1 = s[4 * c + 1];
			a2 = s[4 * c + 2];
			a3 = s[4 * c + 3];
			t = a0 ^ a1 ^ a2 ^ a3;
			d[32 * c +: 8] = a0 ^ t ^ xt(a0 ^ a1);
			d[32 * c + 8 +: 8] = a1 ^ t ^ xt(a1 ^ a2);
			d[32 * c + 16 +: 8] = a2 ^ t ^ xt(a2 ^ a3);
			d[32 * c + 24 +: 8] = a3 ^ t ^ xt(a3 ^ a0);
		end
		aes_round = d ^ k;
	endfunction

	// keep the low n bytes of a 16-byte value, n in 0..16
	function automatic logic [127:0] keep_bytes(input logic [127:0] w, input logic [4:0] n);
		logic [127:0] m;
		for (int i = 0; i < 16; i++)
			m[8 * i +: 8] = (5'(i) < n) ? 8'hff : 8'h00;
		keep_bytes = w & m;
	endfunction
endpackage
`default_nettype wire

// ----- rtl/core/aes_round_three_lane_mac.sv -----
// three-lane aes round mac: sequencer around one shared compression unit
// start: load, 9 constant compressions, fold, then ready again
// data block: accept, then one or two compressions
// finish: as a data block, then init and fold; one or two tag transfers held while stalled
// the shared round unit does one compression per cycle
// arst_n clears lanes, counters, phase, rate, key and the sequencer at once; tag length resets to 16
`timescale 1ns / 1ps
`default_nettype none
module aes_round_three_lane_mac (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic valid,
	output logic stall,
	input wire logic [1:0] operation,
	input wire logic [63:0] block_low,
	input wire logic [63:0] block_high,
	input wire logic [4:0] byte_count,
	output logic out_valid,
	input wire logic out_stall,
	output logic [63:0] tag_low,
	output logic [63:0] tag_high,
	output logic [4:0] valid_bytes,
	output logic last,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [63:0] cfg_data
);
	import armac_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MSG, ST_EXTRA, ST_INIT, ST_FOLD, ST_TAG1, ST_TAG2
	} state_t;

	state_t state_q;
	logic [1:0] rate_q;
	logic [255:0] key_q;
	logic [5:0] tagb_q;
	logic [127:0] l1_q, l2_q, l3_q, s1_q, s2_q, s3_q, msg_q;
	logic [63:0] aad_q, text_q;
	logic [1:0] phase_q;
	logic [3:0] cnt_q;
	logic fin_q;

	logic [1:0] md;
	logic [127:0] x, t, n2, n3, m;
	logic [4:0] cnt_in;
	logic [5:0] tlen;
	logic extra;
	logic in_xfer;

	assign md = (rate_q == 2'd3) ? 2'd0 : rate_q;
	assign m = (state_q == ST_MSG) ? msg_q : ONE_MSG;
	// shared compression unit
	always_comb begin
		x = l2_q ^ l3_q ^ m;
		for (int i = 0; i < 16; i++)
			t[8 * i +: 8] = x[8 * PERM[md][i] +: 8];
		n3 = aes_round(l2_q, m);
		n2 = aes_round(l1_q, m);
	end

	assign cnt_in = (byte_count > 5'd16) ? 5'd16 : byte_count;
	assign tlen = (tagb_q == 6'd0) ? 6'd1 : ((tagb_q > 6'd32) ? 6'd32 : tagb_q);
	assign extra = (md == 2'd2) || (md == 2'd1 && phase_q == 2'd2);
	assign stall = (state_q != ST_IDLE);
	assign in_xfer = valid && !stall;
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_TAG1) || (state_q == ST_TAG2);
	always_comb begin
		logic [127:0] w;
		logic [4:0] n;
		if (state_q == ST_TAG1) begin
			w = l2_q;
			n = (tlen > 6'd16) ? 5'd16 : tlen[4:0];
		end else begin
			w = l3_q;
			n = 5'(tlen - 6'd16);
		end
		{tag_high, tag_low} = keep_bytes(w, n);
		valid_bytes = n;
		last = (state_q == ST_TAG2) || (tlen <= 6'd16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rate_q <= 2'd0;
			key_q <= '0;
			tagb_q <= 6'd16;
			l1_q <= '0;
			l2_q <= '0;
			l3_q <= '0;
			aad_q <= '0;
			text_q <= '0;
			phase_q <= 2'd0;
			cnt_q <= 4'd0;
			fin_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_RATE: rate_q <= cfg_data[1:0];
					REG_KEY0: key_q[63:0] <= cfg_data;
					REG_KEY1: key_q[127:64] <= cfg_data;
					REG_KEY2: key_q[191:128] <= cfg_data;
					REG_KEY3: key_q[255:192] <= cfg_data;
					REG_TAG: tagb_q <= cfg_data[5:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						fin_q <= 1'b0;
						unique case (operation)
							OP_START: begin
								l1_q <= key_q[255:128];
								l2_q <= key_q[127:0];
								l3_q <= {block_high, block_low};
								s1_q <= key_q[255:128];
								s2_q <= key_q[127:0];
								s3_q <= {block_high, block_low};
								aad_q <= '0;
								text_q <= '0;
								phase_q <= 2'd0;
								cnt_q <= 4'd0;
								state_q <= ST_INIT;
							end
							OP_AAD, OP_TEXT: begin
								if (cnt_in != 5'd0) begin
									msg_q <= keep_bytes({block_high, block_low}, cnt_in);
									if (operation == OP_AAD)
										aad_q <= aad_q + {56'd0, cnt_in, 3'd0};
									else
										text_q <= text_q + {56'd0, cnt_in, 3'd0};
									state_q <= ST_MSG;
								end
							end
							OP_FINISH: begin
								msg_q <= {text_q, aad_q};
								fin_q <= 1'b1;
								state_q <= ST_MSG;
							end
							default: ;
						endcase
					end
				end
				ST_MSG, ST_EXTRA: begin
					l1_q <= t;
					l2_q <= n2;
					l3_q <= n3;
					if (state_q == ST_MSG)
						phase_q <= (phase_q >= 2'd2) ? 2'd0 : phase_q + 2'd1;
					if (state_q == ST_MSG && extra) begin
						state_q <= ST_EXTRA;
					end else if (fin_q) begin
						s1_q <= t;
						s2_q <= n2;
						s3_q <= n3;
						cnt_q <= 4'd0;
						state_q <= ST_INIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_INIT: begin
					l1_q <= t;
					l2_q <= n2;
					l3_q <= n3;
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(INIT_ROUNDS - 1))
						state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					l1_q <= l1_q ^ s1_q;
					l2_q <= l2_q ^ s2_q;
					l3_q <= l3_q ^ s3_q;
					state_q <= fin_q ? ST_TAG1 : ST_IDLE;
				end
				ST_TAG1: begin
					if (!out_stall)
						state_q <= (tlen > 6'd16) ? ST_TAG2 : ST_IDLE;
				end
				ST_TAG2: begin
					if (!out_stall)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/armac_checker.sv -----
// port-level checker for the three-lane mac, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "aes_round_three_lane_mac_macros.svh"
module armac_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [4:0] valid_bytes,
	input wire logic last,
	input wire logic cfg_ready
);
	// no input taken while a tag is offered
	`ARM_ASSERT_IMP(a_busy_out, clk, arst_n, out_valid, stall)
	// a stalled tag chunk keeps its length
	`ARM_ASSERT_NXT(a_hold, clk, arst_n, out_valid && out_stall, $stable(valid_bytes))
	// chunks carry at least one byte and at most 16
	`ARM_ASSERT_IMP(a_len, clk, arst_n, out_valid, valid_bytes != 5'd0 && valid_bytes <= 5'd16)
	// a chunk followed by another one is full
	`ARM_ASSERT_IMP(a_full, clk, arst_n, out_valid && !last, valid_bytes == 5'd16)
	// register writes only open while input is open
	`ARM_ASSERT_IMP(a_cfg, clk, arst_n, 1'b1, cfg_ready == !stall)
endmodule
bind aes_round_three_lane_mac armac_checker u_armac_checker (
	.clk(clk), .arst_n(arst_n), .stall(stall), .out_valid(out_valid),
	.out_stall(out_stall), .valid_bytes(valid_bytes), .last(last), .cfg_ready(cfg_ready));
`default_nettype wire

// ----- tb/aes_round_three_lane_mac_test.sv -----
// testbench for the three-lane aes round mac: directed and random traffic against a predictor
`timescale 1ns / 1ps
`default_nettype none
module aes_round_three_lane_mac_test;
	import armac_pkg::*;

	typedef struct {
		logic [63:0] lo;
		logic [63:0] hi;
		logic [4:0] nbytes;
		logic fin;
	} tag_chunk_t;

	localparam int unsigned IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic valid;
	logic stall;
	logic [1:0] operation;
	logic [63:0] block_low;
	logic [63:0] block_high;
	logic [4:0] byte_count;
	logic out_valid;
	logic out_stall;
	logic [63:0] tag_low;
	logic [63:0] tag_high;
	logic [4:0] valid_bytes;
	logic last;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [63:0] cfg_data;

	// predictor state and register copies
	logic [127:0] lane_a, lane_b, lane_c;
	logic [63:0] aad_bits, text_bits;
	logic [1:0] phase;
	logic [1:0] mode_reg;
	logic [63:0] key_reg [4];
	logic [5:0] tag_len_reg;

	tag_chunk_t expected_tags [$];
	int errors;
	int idle_cycles;
	bit quiet_tail;
	bit hold_off;
	int results_seen;

	aes_round_three_lane_mac u_dut (
		.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall),
		.operation(operation), .block_low(block_low), .block_high(block_high),
		.byte_count(byte_count), .out_valid(out_valid), .out_stall(out_stall),
		.tag_low(tag_low), .tag_high(tag_high), .valid_bytes(valid_bytes), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [7:0] gmul2(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [127:0] round_enc(input logic [127:0] st, input logic [127:0] rk);
		logic [7:0] sb [16];
		logic [7:0] b0, b1, b2, b3, sum;
		logic [127:0] r;
		for (int col = 0; col < 4; col++)
			for (int row = 0; row < 4; row++)
				sb[row + 4 * col] = SBOX[st[8 * (row + 4 * ((col + row) % 4)) +: 8]];
		for (int col = 0; col < 4; col++) begin
			b0 = sb[4 * col];
			b1 = sb[4 * col + 1];
			b2 = sb[4 * col + 2];
			b3 = sb[4 * col + 3];
			sum = b0 ^ b1 ^ b2 ^ b3;
			r[32 * col +: 8] = b0 ^ sum ^ gmul2(b0 ^ b1);
			r[32 * col + 8 +: 8] = b1 ^ sum ^ gmul2(b1 ^ b2);
			r[32 * col + 16 +: 8] = b2 ^ sum ^ gmul2(b2 ^ b3);
			r[32 * col + 24 +: 8] = b3 ^ sum ^ gmul2(b3 ^ b0);
		end
		return r ^ rk;
	endfunction

	function automatic logic [127:0] low_bytes(input logic [127:0] w, input int n);
		logic [127:0] m;
		for (int i = 0; i < 16; i++)
			m[8 * i +: 8] = (i < n) ? 8'hff : 8'h00;
		return w & m;
	endfunction

	function automatic int mode_sel();
		return (mode_reg == 2'd3) ? 0 : int'(mode_reg);
	endfunction

	task automatic compress_lanes(input logic [127:0] msg);
		logic [127:0] mix, shuffled;
		int p;
		p = mode_sel();
		mix = lane_b ^ lane_c ^ msg;
		for (int i = 0; i < 16; i++)
			shuffled[8 * i +: 8] = mix[8 * PERM[p][i] +: 8];
		lane_c = round_enc(lane_b, msg);
		lane_b = round_enc(lane_a, msg);
		lane_a = shuffled;
	endtask

	task automatic fold_lanes();
		logic [127:0] sa, sb, sc;
		sa = lane_a;
		sb = lane_b;
		sc = lane_c;
		for (int i = 0; i < INIT_ROUNDS; i++)
			compress_lanes(ONE_MSG);
		lane_a ^= sa;
		lane_b ^= sb;
		lane_c ^= sc;
	endtask

	task automatic absorb_block(input logic [127:0] blk);
		int p;
		p = mode_sel();
		compress_lanes(blk);
		if (p == 2 || (p == 1 && phase == 2'd2))
			compress_lanes(ONE_MSG);
		phase = (phase >= 2'd2) ? 2'd0 : phase + 2'd1;
	endtask

	task automatic predict_mac(input logic [1:0] op, input logic [63:0] lo,
		input logic [63:0] hi, input logic [4:0] cnt);
		int n, t;
		tag_chunk_t c;
		n = (cnt > 16) ? 16 : int'(cnt);
		case (op)
			OP_START: begin
				lane_a = {key_reg[3], key_reg[2]};
				lane_b = {key_reg[1], key_reg[0]};
				lane_c = {hi, lo};
				aad_bits = '0;
				text_bits = '0;
				phase = '0;
				fold_lanes();
			end
			OP_AAD, OP_TEXT: begin
				if (n != 0) begin
					if (op == OP_AAD)
						aad_bits += 64'(n * 8);
					else
						text_bits += 64'(n * 8);
					absorb_block(low_bytes({hi, lo}, n));
				end
			end
			default: begin
				t = int'(tag_len_reg);
				if (t < 1) t = 1;
				if (t > 32) t = 32;
				absorb_block({text_bits, aad_bits});
				fold_lanes();
				n = (t > 16) ? 16 : t;
				{c.hi, c.lo} = low_bytes(lane_b, n);
				c.nbytes = 5'(n);
				c.fin = (t <= 16);
				expected_tags.push_back(c);
				if (t > 16) begin
					{c.hi, c.lo} = low_bytes(lane_c, t - 16);
					c.nbytes = 5'(t - 16);
					c.fin = 1'b1;
					expected_tags.push_back(c);
				end
			end
		endcase
	endtask

	// idle between transfers in short random bursts; valid stays up after a
	// transfer until the next driving task takes over
	task automatic send_item(input logic [1:0] op, input logic [63:0] lo,
		input logic [63:0] hi, input logic [4:0] cnt);
		cfg_valid <= 1'b0;
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		valid <= 1'b1;
		operation <= op;
		block_low <= lo;
		block_high <= hi;
		byte_count <= cnt;
		@(posedge clk);
		while (stall) @(posedge clk);
		predict_mac(op, lo, hi, cnt);
	endtask

	task automatic wait_drained();
		valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (expected_tags.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
		valid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_RATE: mode_reg = data[1:0];
			REG_KEY0: key_reg[0] = data;
			REG_KEY1: key_reg[1] = data;
			REG_KEY2: key_reg[2] = data;
			REG_KEY3: key_reg[3] = data;
			REG_TAG: tag_len_reg = data[5:0];
			default: ;
		endcase
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic write_keys_random();
		write_reg(REG_KEY0, rand64());
		write_reg(REG_KEY1, rand64());
		write_reg(REG_KEY2, rand64());
		write_reg(REG_KEY3, rand64());
	endtask

	task automatic test_reset_defaults();
		send_item(OP_START, '0, '0, 5'd0);
		send_item(OP_AAD, 64'h0123456789abcdef, 64'hfedcba9876543210, 5'd16);
		send_item(OP_FINISH, '0, '0, 5'd0);
		wait_drained();
	endtask

	task automatic test_directed_edges();
		write_reg(REG_KEY0, '1);
		write_reg(REG_KEY1, '0);
		write_reg(REG_KEY2, '1);
		write_reg(REG_KEY3, 64'h5555aaaa5555aaaa);
		write_reg(REG_TAG, 6'd32);
		write_reg(REG_RATE, 2'd2);
		send_item(OP_START, '1, '1, 5'd31);
		send_item(OP_AAD, '1, '1, 5'd0);
		send_item(OP_AAD, '1, '1, 5'd1);
		send_item(OP_TEXT, '1, '1, 5'd8);
		send_item(OP_TEXT, '1, '1, 5'd9);
		send_item(OP_TEXT, '1, '1, 5'd31);
		send_item(OP_AAD, '1, '1, 5'd17);
		send_item(OP_FINISH, '1, '1, 5'd16);
		wait_drained();
		// tag length zero, above range, and unused rate mode
		write_reg(REG_TAG, 6'd0);
		write_reg(REG_RATE, 2'd3);
		send_item(OP_TEXT, 64'h8000000000000001, '0, 5'd16);
		send_item(OP_FINISH, '0, '0, 5'd0);
		wait_drained();
		write_reg(REG_TAG, 6'd63);
		write_reg(REG_RATE, 2'd1);
		send_item(OP_START, 64'h0f0f0f0f0f0f0f0f, 64'hf0f0f0f0f0f0f0f0, 5'd0);
		for (int i = 0; i < 4; i++)
			send_item(OP_AAD, rand64(), rand64(), 5'(i + 5));
		send_item(OP_FINISH, '0, '0, 5'd0);
		write_reg(REG_TAG, 6'd17);
		send_item(OP_FINISH, '0, '0, 5'd0);
		wait_drained();
	endtask

	task automatic run_message(input int nblocks);
		logic [1:0] op;
		logic [4:0] cnt;
		send_item(OP_START, rand64(), rand64(), 5'($urandom_range(0, 31)));
		for (int i = 0; i < nblocks; i++) begin
			op = ($urandom_range(0, 1) != 0) ? OP_AAD : OP_TEXT;
			case ($urandom_range(0, 5))
				0: cnt = 5'($urandom_range(0, 31));
				1: cnt = 5'($urandom_range(1, 15));
				default: cnt = 5'd16;
			endcase
			send_item(op, rand64(), rand64(), cnt);
		end
		send_item(OP_FINISH, rand64(), rand64(), 5'($urandom_range(0, 31)));
	endtask

	task automatic test_random_messages(input int items);
		int sent;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(0, 9) == 0) begin
				// stray item outside a well-formed message
				send_item(2'($urandom_range(1, 3)), rand64(), rand64(),
					5'($urandom_range(0, 31)));
				sent++;
			end else begin
				int nb;
				nb = $urandom_range(0, 12);
				run_message(nb);
				sent += nb + 2;
			end
			if ($urandom_range(0, 15) == 0) begin
				wait_drained();
				write_reg(REG_RATE, 2'($urandom_range(0, 3)));
				write_reg(REG_TAG, 6'($urandom_range(0, 63)));
				write_keys_random();
			end
		end
		wait_drained();
	endtask

	task automatic test_output_backpressure();
		write_reg(REG_TAG, 6'd32);
		hold_off = 1'b1;
		for (int i = 0; i < 6; i++)
			run_message(2);
		hold_off = 1'b0;
		wait_drained();
	endtask

	// receiver stall process: random bursts, or a long hold-off when asked
	initial begin
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
			end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	// tag checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_tags.size() == 0) begin
				$display("%0t: unexpected tag transfer lo=%h hi=%h", $time, tag_low, tag_high);
				errors++;
			end else begin
				tag_chunk_t e;
				e = expected_tags.pop_front();
				if (tag_low !== e.lo) begin
					$display("%0t: tag_low expected %h actual %h", $time, e.lo, tag_low);
					errors++;
				end
				if (tag_high !== e.hi) begin
					$display("%0t: tag_high expected %h actual %h", $time, e.hi, tag_high);
					errors++;
				end
				if (valid_bytes !== e.nbytes) begin
					$display("%0t: valid_bytes expected %0d actual %0d", $time, e.nbytes,
						valid_bytes);
					errors++;
				end
				if (last !== e.fin) begin
					$display("%0t: last expected %b actual %b", $time, e.fin, last);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((valid && !stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		valid = 1'b0;
		operation = OP_START;
		block_low = '0;
		block_high = '0;
		byte_count = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_RATE;
		cfg_data = '0;
		errors = 0;
		idle_cycles = 0;
		quiet_tail = 1'b0;
		hold_off = 1'b0;
		results_seen = 0;
		lane_a = '0;
		lane_b = '0;
		lane_c = '0;
		aad_bits = '0;
		text_bits = '0;
		phase = '0;
		mode_reg = '0;
		for (int i = 0; i < 4; i++) key_reg[i] = '0;
		tag_len_reg = 6'd16;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed_edges();
		write_reg(REG_RATE, 2'd0);
		write_reg(REG_TAG, 6'd1);
		write_keys_random();
		test_random_messages(1500);
		test_output_backpressure();
		quiet_tail = 1'b1;
		test_random_messages(300);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire

// ----- aes_round_three_lane_mac.f -----
+incdir+rtl/core
rtl/core/armac_pkg.sv
rtl/core/aes_round_three_lane_mac.sv
rtl/core/armac_checker.sv
tb/aes_round_three_lane_mac_test.sv
